// ===== src/ifr_pkg.sv =====
// Shared types and constants of the sensor frame receiver.
package ifr_pkg;

   localparam logic [7:0] HEADER_BYTE = 8'hFF;
   localparam int         FRAME_LEN   = 18;
   localparam int         PAYLOAD_LEN = FRAME_LEN - 2;
   localparam int         NUM_WORDS   = PAYLOAD_LEN / 2;
   localparam int         POS_W       = 5;

   // Position codes: hunting, first payload byte next, last payload byte next.
   localparam logic [POS_W-1:0] POS_HUNT         = POS_W'(0);
   localparam logic [POS_W-1:0] POS_FIRST        = POS_W'(1);
   localparam logic [POS_W-1:0] POS_LAST_PAYLOAD = POS_W'(PAYLOAD_LEN);

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
      logic signed [15:0] yaw;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] temperature;
      logic signed [15:0] stamp;
      logic               checksum_ok;
   } ifr_result_type;

   typedef struct packed {
      logic check_next;   // the next byte taken is the check byte
      logic frame_done;   // this cycle's byte closes a frame
   } ifr_status_type;

endpackage

// ===== src/ifr_if.sv =====
// Handshake channels of the sensor frame receiver.
interface ifr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ifr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] roll;
   logic signed [15:0] pitch;
   logic signed [15:0] yaw;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic signed [15:0] temperature;
   logic signed [15:0] stamp;
   logic               checksum_ok;

   modport source (output valid, output roll, output pitch, output yaw,
                   output accel_x, output accel_y, output accel_z,
                   output temperature, output stamp, output checksum_ok,
                   input ready);
   modport sink   (input valid, input roll, input pitch, input yaw,
                   input accel_x, input accel_y, input accel_z,
                   input temperature, input stamp, input checksum_ok,
                   output ready);
endinterface

// ===== src/imu_frame_receiver.sv =====
// Top level of the sensor frame receiver: input register, framer, result register.
//
// Usage
// - req_ch carries one received serial byte per item (rx_byte). Bytes are
//   dropped until the header byte 0xFF; the 17 bytes after it are taken as
//   16 payload bytes and a check byte, whatever their values.
// - rsp_ch carries one item per frame: eight signed big-endian 16-bit words
//   (roll, pitch, yaw, accel_x/y/z, temperature, stamp) and checksum_ok,
//   which is set when the 8-bit sum of the payload equals the check byte.
//   A frame with a bad sum is still delivered, with checksum_ok clear.
// - Throughput: one byte per cycle while no check byte is held in the input
//   register (see Stall). The framer works on each byte while it sits there
//   and updates its state at the edge where the byte leaves the register; a
//   check byte then loads the frame's result into the result register.
// - Reset (synchronous, active high): both registers empty, framer back to
//   hunting for the header with the byte sum cleared.
// - Stall: a result waits in the result register while rsp_ch.ready is low.
//   Payload bytes keep flowing; only a check byte that would need the still
//   occupied result register holds in the input register, and req_ch.ready
//   falls until the result is taken.
module imu_frame_receiver (
   input  logic       clock,
   input  logic       reset,
   ifr_req_if.sink    req_ch,
   ifr_rsp_if.source  rsp_ch
);
   import ifr_pkg::*;

   // input register
   logic           in_valid_ff, in_valid_in;
   byte_type       in_byte_ff, in_byte_in;

   // result register
   logic           rsp_valid_ff, rsp_valid_in;
   ifr_result_type rsp_data_ff, rsp_data_in;

   ifr_status_type fr_status;
   ifr_result_type fr_result;
   logic           req_take;
   logic           rsp_take;
   logic           advance;
   logic           out_blocked;

   assign req_take    = req_ch.valid && req_ch.ready;
   assign rsp_take    = rsp_valid_ff && rsp_ch.ready;
   // result register full and not emptied this cycle
   assign out_blocked = rsp_valid_ff && !rsp_ch.ready;
   // hold a check byte while the result register is occupied
   assign advance     = in_valid_ff && !(fr_status.check_next && out_blocked);
   assign req_ch.ready = !in_valid_ff || advance;

   ifr_framer u_framer (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .status  (fr_status),
      .result  (fr_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_ch.rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fr_status.frame_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = fr_result;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.roll        = rsp_data_ff.roll;
   assign rsp_ch.pitch       = rsp_data_ff.pitch;
   assign rsp_ch.yaw         = rsp_data_ff.yaw;
   assign rsp_ch.accel_x     = rsp_data_ff.accel_x;
   assign rsp_ch.accel_y     = rsp_data_ff.accel_y;
   assign rsp_ch.accel_z     = rsp_data_ff.accel_z;
   assign rsp_ch.temperature = rsp_data_ff.temperature;
   assign rsp_ch.stamp       = rsp_data_ff.stamp;
   assign rsp_ch.checksum_ok = rsp_data_ff.checksum_ok;

   // a frame never closes into a result register that is full and not emptied this cycle
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      fr_status.frame_done |-> (!rsp_valid_ff || rsp_ch.ready))
      else $error("result register overwritten");

   // a new result appears only after a check byte was worked on
   a_result_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fr_status.frame_done))
      else $error("result without a closed frame");

   // a held byte stays in the input register
   a_input_hold : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("held input byte lost");

endmodule

// ===== src/ifr_framer.sv =====
// Frame tracker: header hunt, payload shift line, byte sum and result decode.
module ifr_framer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            rx_byte,
   output ifr_pkg::ifr_status_type status,
   output ifr_pkg::ifr_result_type result
);
   import ifr_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   byte_type         sum_ff, sum_in;
   byte_type         store_ff [PAYLOAD_LEN];
   byte_type         store_in [PAYLOAD_LEN];
   logic             is_payload;

   assign is_payload = (pos_ff != POS_HUNT) && (pos_ff <= POS_LAST_PAYLOAD);

   always_comb begin
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      store_in = store_ff;
      if (step) begin
         if (pos_ff == POS_HUNT) begin
            if (rx_byte == HEADER_BYTE) begin
               pos_in = POS_FIRST;
               sum_in = '0;
            end
         end else if (is_payload) begin
            // shift towards entry 0, so the first payload byte ends there
            for (int i = 0; i < PAYLOAD_LEN - 1; i++) begin
               store_in[i] = store_ff[i+1];
            end
            store_in[PAYLOAD_LEN-1] = rx_byte;
            sum_in = sum_ff + rx_byte;
            pos_in = pos_ff + POS_W'(1);
         end else begin
            pos_in = POS_HUNT;
            sum_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_HUNT;
         sum_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

   always_comb begin
      status.check_next = (pos_ff != POS_HUNT) && !is_payload;
      status.frame_done = step && status.check_next;
   end

   always_comb begin
      result.roll        = signed'({store_ff[0],  store_ff[1]});
      result.pitch       = signed'({store_ff[2],  store_ff[3]});
      result.yaw         = signed'({store_ff[4],  store_ff[5]});
      result.accel_x     = signed'({store_ff[6],  store_ff[7]});
      result.accel_y     = signed'({store_ff[8],  store_ff[9]});
      result.accel_z     = signed'({store_ff[10], store_ff[11]});
      result.temperature = signed'({store_ff[12], store_ff[13]});
      result.stamp       = signed'({store_ff[14], store_ff[15]});
      result.checksum_ok = (sum_ff == rx_byte);
   end

endmodule

// ===== tb/imu_frame_receiver_tb.sv =====
// Self-checking testbench of the sensor frame receiver: byte stimulus, frame predictor, scoreboard.
`timescale 1ns / 1ps

module imu_frame_receiver_tb;
   import ifr_pkg::*;

   localparam int ITEM_TARGET   = 1150;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 8;

   // Frame predictor and store of expected frames. Accepted bytes go in through
   // note_byte; every frame seen on the result channel goes through check_frame.
   class frame_scoreboard;
      logic [POS_W-1:0] position = POS_HUNT;
      byte_type         byte_sum = '0;
      byte_type         payload [PAYLOAD_LEN];
      ifr_result_type   expected_frames [$];
      int               failures = 0;

      function void note_byte(input byte_type value);
         ifr_result_type frame;
         logic [15:0]    words [NUM_WORDS];
         if (position == POS_HUNT) begin
            // drop everything but the header while hunting
            if (value == HEADER_BYTE) begin
               position = POS_FIRST;
               byte_sum = '0;
            end
         end else if (position <= POS_LAST_PAYLOAD) begin
            payload[position - 1] = value;
            byte_sum = byte_sum + value;
            position = position + 1'b1;
         end else begin
            // check byte: close the frame, big-endian words
            for (int k = 0; k < NUM_WORDS; k++)
               words[k] = {payload[2 * k], payload[2 * k + 1]};
            frame.roll        = words[0];
            frame.pitch       = words[1];
            frame.yaw         = words[2];
            frame.accel_x     = words[3];
            frame.accel_y     = words[4];
            frame.accel_z     = words[5];
            frame.temperature = words[6];
            frame.stamp       = words[7];
            frame.checksum_ok = (byte_sum == value);
            expected_frames.push_back(frame);
            position = POS_HUNT;
            byte_sum = '0;
         end
      endfunction

      function void report(input string what, input logic [15:0] want, input logic [15:0] got);
         failures++;
         $display("%0t: %s expected %h, got %h", $time, what, want, got);
      endfunction

      function void check_frame(input ifr_result_type seen);
         ifr_result_type want;
         if (expected_frames.size() == 0) begin
            failures++;
            $display("%0t: frame expected none, got %h", $time, seen);
            return;
         end
         want = expected_frames.pop_front();
         if (seen.roll !== want.roll)               report("roll", want.roll, seen.roll);
         if (seen.pitch !== want.pitch)             report("pitch", want.pitch, seen.pitch);
         if (seen.yaw !== want.yaw)                 report("yaw", want.yaw, seen.yaw);
         if (seen.accel_x !== want.accel_x)         report("accel_x", want.accel_x, seen.accel_x);
         if (seen.accel_y !== want.accel_y)         report("accel_y", want.accel_y, seen.accel_y);
         if (seen.accel_z !== want.accel_z)         report("accel_z", want.accel_z, seen.accel_z);
         if (seen.temperature !== want.temperature)
            report("temperature", want.temperature, seen.temperature);
         if (seen.stamp !== want.stamp)             report("stamp", want.stamp, seen.stamp);
         if (seen.checksum_ok !== want.checksum_ok)
            report("checksum_ok", 16'(want.checksum_ok), 16'(seen.checksum_ok));
      endfunction

      function int pending();
         return expected_frames.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   ifr_req_if req_ch ();
   ifr_rsp_if rsp_ch ();

   frame_scoreboard board = new;

   // idle rates in percent, set per phase by the stimulus process
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int items_sent    = 0;
   bit hold_request  = 1'b0;

   imu_frame_receiver u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard limit on run time, far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // Receiver: drive ready at the falling edge. Hold off once for a long
   // stretch when asked, so the result register stays full and the block
   // must stall its input.
   initial begin
      bit hold_taken;
      hold_taken = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Monitor: sample accepted frames at the rising edge.
   always @(posedge clock) begin
      ifr_result_type seen;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         seen.roll        = rsp_ch.roll;
         seen.pitch       = rsp_ch.pitch;
         seen.yaw         = rsp_ch.yaw;
         seen.accel_x     = rsp_ch.accel_x;
         seen.accel_y     = rsp_ch.accel_y;
         seen.accel_z     = rsp_ch.accel_z;
         seen.temperature = rsp_ch.temperature;
         seen.stamp       = rsp_ch.stamp;
         seen.checksum_ok = rsp_ch.checksum_ok;
         board.check_frame(seen);
      end
   end

   // Offer one byte, idling first at random; return at the falling edge after
   // it was taken. Only bytes that belong to a frame count toward the target.
   task automatic send_byte(input byte_type value, input bit counts);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= value;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      board.note_byte(value);
      if (counts)
         items_sent++;
      @(negedge clock);
   endtask

   // Payload bytes lean towards the header value and the sign boundaries.
   function automatic byte_type pick_byte();
      case ($urandom_range(7))
         0:       return HEADER_BYTE;
         1:       return 8'h00;
         2:       return 8'h80;
         3:       return 8'h7F;
         default: return byte_type'($urandom_range(255));
      endcase
   endfunction

   // Header, payload and check byte; a bad check byte is always off by
   // a nonzero amount.
   task automatic send_frame(input bit good_sum);
      byte_type sum;
      byte_type value;
      sum = '0;
      send_byte(HEADER_BYTE, 1'b1);
      for (int k = 0; k < PAYLOAD_LEN; k++) begin
         value = pick_byte();
         sum = sum + value;
         send_byte(value, 1'b1);
      end
      if (good_sum)
         send_byte(sum, 1'b1);
      else
         send_byte(sum + byte_type'($urandom_range(255, 1)), 1'b1);
   endtask

   // Random traffic up to a running item count: mostly clean frames, some with
   // bad sums, line noise between frames and now and then a cut-off frame
   // that swallows the next header as payload.
   task automatic send_stream(input int target);
      int pick;
      while (items_sent < target) begin
         repeat ($urandom_range(3) == 0 ? $urandom_range(3, 1) : 0)
            send_byte(byte_type'($urandom_range(254)), 1'b0);
         pick = $urandom_range(99);
         if (pick < 80) begin
            send_frame(1'b1);
         end else if (pick < 95) begin
            send_frame(1'b0);
         end else begin
            send_byte(HEADER_BYTE, 1'b1);
            repeat ($urandom_range(PAYLOAD_LEN - 1, 1)) send_byte(pick_byte(), 1'b1);
         end
      end
   endtask

   initial begin
      byte_type corner [PAYLOAD_LEN];
      byte_type sum;
      corner = '{8'h7F, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF,
                 8'h00, 8'h01, 8'hFF, 8'h80, 8'h00, 8'hFF, 8'h80, 8'h01};
      reset = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // phase one: sender idles rarely, receiver stalls often
      req_idle_pct  = 6;
      rsp_stall_pct = 84;

      // directed: noise while hunting, then a frame of extreme words with
      // header values inside the payload
      send_byte(8'h00, 1'b0);
      send_byte(8'hFE, 1'b0);
      sum = '0;
      send_byte(HEADER_BYTE, 1'b1);
      foreach (corner[k]) begin
         sum = sum + corner[k];
         send_byte(corner[k], 1'b1);
      end
      send_byte(sum, 1'b1);

      send_stream(ITEM_TARGET / 3);

      // phase two: the other way round
      req_idle_pct  = 84;
      rsp_stall_pct = 6;
      send_stream(2 * ITEM_TARGET / 3);

      // phase three: no idling, one long hold-off at the receiver
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_request  = 1'b1;
      send_stream(ITEM_TARGET);
      req_ch.valid <= 1'b0;

      // drain, then allow the pipeline to settle
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.failures == 0 && board.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
